@@ src/assert_macros.svh @@
// Assertion macros used by the blur unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ src/bb3_pkg.sv @@
// Shared types and constants of the 3x3 box blur unit.
`default_nettype none

package bb3_pkg;

    // Field and register widths.
    localparam int CFG_W      = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int PIX_W      = 32;
    localparam int RGB_W      = 24;
    localparam int CH_W       = 8;
    localparam int COORD_W    = 10;
    localparam int SUM_W      = 12;

    // Geometry limits and reset values.
    localparam int MIN_DIM = 2;
    localparam logic [CFG_W-1:0] RESET_FRAME_WIDTH  = 11'd800;
    localparam logic [CFG_W-1:0] RESET_FRAME_HEIGHT = 11'd600;

    // Division by nine: floor(s / 9) == (s * 3641) >> 15 for s below 32768.
    localparam logic [SUM_W-1:0] DIV9_MUL   = 12'd3641;
    localparam int               DIV9_SHIFT = 15;

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hFF;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [RGB_W-1:0] t_rgb;

    // Position of a pixel relative to the frame border.
    typedef struct packed {
        logic x_ge1;
        logic x_ge2;
        logic y_ge1;
        logic y_ge2;
        logic x_last;
        logic y_last;
    } t_pos_flags;

    // One blurred result on its way to the output register.
    typedef struct packed {
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [PIX_W-1:0]   pixel;
        logic               last_of_run;
        logic               frame_done;
    } t_result;

endpackage

`default_nettype wire

@@ src/bb3_line_store.sv @@
// Two line memories holding the previous two rows of RGB data.
`default_nettype none

module bb3_line_store
    import bb3_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  wire logic          i_clk,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output      t_rgb          o_rd_a,
    output      t_rgb          o_rd_b,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_rgb          i_wr_a,
    input  wire t_rgb          i_wr_b
);

    t_rgb r_mem_a [DEPTH];
    t_rgb r_mem_b [DEPTH];
    t_rgb r_rd_a;
    t_rgb r_rd_b;

    // Previous row: read when a pixel enters, rewritten when it leaves.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_a[i_wr_addr] <= i_wr_a;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem_a[i_rd_addr];
        end
    end

    // Row before that: receives what the previous row held.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem_b[i_wr_addr] <= i_wr_b;
        end
        if (i_rd_en) begin
            r_rd_b <= r_mem_b[i_rd_addr];
        end
    end

    assign o_rd_a = r_rd_a;
    assign o_rd_b = r_rd_b;

endmodule

`default_nettype wire

@@ src/bb3_window.sv @@
// Working pixel register, 3x3 window columns and per-pixel result sequencer.
`default_nettype none

module bb3_window
    import bb3_pkg::*;
#(
    parameter int COL_W = 10,
    parameter int ROW_W = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clear,
    input  wire logic             i_load,
    input  wire t_rgb             i_rgb,
    input  wire logic [COL_W-1:0] i_col,
    input  wire logic [ROW_W-1:0] i_row,
    input  wire t_pos_flags       i_flags,
    input  wire t_rgb             i_prev_a,
    input  wire t_rgb             i_prev_b,
    input  wire logic             i_res_ready,
    output      logic             o_res_valid,
    output      t_result          o_res,
    output      logic             o_full,
    output      logic             o_advance,
    output      logic [COL_W-1:0] o_col,
    output      t_rgb             o_rgb
);

    logic             r_valid;
    logic [3:0]       r_pend;
    t_rgb             r_rgb;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_pos_flags       r_flags;
    t_rgb             r_wc [6];

    t_rgb             grid [4][4];
    logic [1:0]       sel;
    logic [3:0]       pend_rest;
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    logic [COL_W-1:0] ocol;
    logic [ROW_W-1:0] orow;
    logic             take;
    logic [3:0]       new_pend;

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [2*SUM_W-1:0] p;
        p = (2*SUM_W)'(s) * (2*SUM_W)'(DIV9_MUL);
        return p[DIV9_SHIFT+CH_W-1:DIV9_SHIFT];
    endfunction

    // Window grid: columns x-2..x+1, rows y-2..y+1; the last column and row are zero.
    always_comb begin
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                grid[c][r] = '0;
            end
        end
        for (int r = 0; r < 3; r++) begin
            grid[0][r] = r_flags.x_ge2 ? r_wc[r] : '0;
            grid[1][r] = r_flags.x_ge1 ? r_wc[3+r] : '0;
        end
        grid[2][0] = r_flags.y_ge2 ? i_prev_b : '0;
        grid[2][1] = r_flags.y_ge1 ? i_prev_a : '0;
        grid[2][2] = r_rgb;
    end

    // Pick the next pending result: upper row first, then left column first.
    always_comb begin
        if (r_pend[0]) begin
            sel = 2'd0;
        end else if (r_pend[1]) begin
            sel = 2'd1;
        end else if (r_pend[2]) begin
            sel = 2'd2;
        end else begin
            sel = 2'd3;
        end
        pend_rest = r_pend & ~(4'b0001 << sel);
    end

    // Channel sums over the selected 3x3 neighbourhood.
    always_comb begin
        logic [1:0] gc;
        logic [1:0] gr;
        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int dc = 0; dc < 3; dc++) begin
            for (int dr = 0; dr < 3; dr++) begin
                gc = 2'(dc) + {1'b0, sel[0]};
                gr = 2'(dr) + {1'b0, sel[1]};
                sum_r = sum_r + SUM_W'(grid[gc][gr][23:16]);
                sum_g = sum_g + SUM_W'(grid[gc][gr][15:8]);
                sum_b = sum_b + SUM_W'(grid[gc][gr][7:0]);
            end
        end
    end

    // Result fields of the selected neighbourhood.
    always_comb begin
        ocol = sel[0] ? r_col : r_col - COL_W'(1);
        orow = sel[1] ? r_row : r_row - ROW_W'(1);
        o_res.col         = COORD_W'(ocol);
        o_res.row         = COORD_W'(orow);
        o_res.pixel       = {div9(sum_r), div9(sum_g), div9(sum_b), ALPHA_OPAQUE};
        o_res.last_of_run = (pend_rest == 4'b0000);
        o_res.frame_done  = sel[0] & sel[1];
    end

    // Handshake toward the output register and toward the input side.
    always_comb begin
        o_res_valid = r_valid && (r_pend != 4'b0000);
        take        = o_res_valid && i_res_ready;
        o_advance   = r_valid && ((r_pend == 4'b0000) || (take && (pend_rest == 4'b0000)));
        new_pend    = {i_flags.y_last & i_flags.x_last, i_flags.y_last & i_flags.x_ge1,
                       i_flags.y_ge1 & i_flags.x_last, i_flags.y_ge1 & i_flags.x_ge1};
    end

    // Control of the working pixel register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_valid <= 1'b0;
            r_pend  <= 4'b0000;
        end else begin
            if (take) begin
                r_pend <= pend_rest;
            end
            if (i_load) begin
                r_valid <= 1'b1;
                r_pend  <= new_pend;
            end else if (o_advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Payload of the working pixel register.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rgb   <= i_rgb;
            r_col   <= i_col;
            r_row   <= i_row;
            r_flags <= i_flags;
        end
    end

    // Window columns shift by one as each pixel leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int i = 0; i < 6; i++) begin
                r_wc[i] <= '0;
            end
        end else if (o_advance) begin
            for (int i = 0; i < 3; i++) begin
                r_wc[i]   <= grid[1][i];
                r_wc[3+i] <= grid[2][i];
            end
        end
    end

    assign o_full = r_valid;
    assign o_col  = r_col;
    assign o_rgb  = r_rgb;

endmodule

`default_nettype wire

@@ src/bb3_out_stage.sv @@
// Output register that holds one result beat until the receiver takes it.
`default_nettype none

module bb3_out_stage
    import bb3_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_load,
    input  wire t_result            i_res,
    output      logic               o_ready,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      logic [COORD_W-1:0] o_out_col,
    output      logic [COORD_W-1:0] o_out_row,
    output      logic [PIX_W-1:0]   o_pixel_out,
    output      logic               o_last_of_run,
    output      logic               o_frame_done
);

    logic    r_valid;
    t_result r_res;

    // The register may take a new beat when empty or when its beat leaves.
    assign o_ready = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_col     = r_res.col;
    assign o_out_row     = r_res.row;
    assign o_pixel_out   = r_res.pixel;
    assign o_last_of_run = r_res.last_of_run;
    assign o_frame_done  = r_res.frame_done;

endmodule

`default_nettype wire

@@ src/box_blur_3x3_rgb_unit.sv @@
// Top level of the 3x3 box blur unit for RGBA8888 raster streams.
//
// Pixels enter in raster order on the input channel (i_in_valid, o_in_stall,
// i_pixel_in); blurred pixels leave on the output channel (o_out_valid,
// i_out_stall) with their column, row, a last-of-run flag and a frame-done flag.
// Frame width and height are written through the plain config port while the
// unit is idle; any write restarts the frame at the top-left pixel.
//
// Results go from the working pixel register to the output register. Throughput:
// one pixel per clock inside the frame unless the receiver stalls. A pixel that
// ends a row below the first gives two results, each pixel of the last row but
// its first gives two, and the final pixel of the frame gives four; the single
// output register moves one result per beat, so the input stalls for those extra
// beats. A new pixel is still taken while a finished result waits at the output.
//
// Reset clears the geometry to 800x600, the position counters and the window;
// the line memories need no clearing pass, as rows above the frame are masked.
// When the receiver stalls, the output beat holds and the input stalls once the
// working register is also full.
`default_nettype none
`include "assert_macros.svh"

module box_blur_3x3_rgb_unit
    import bb3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_in_valid,
    output      logic                 o_in_stall,
    input  wire logic [PIX_W-1:0]     i_pixel_in,
    output      logic                 o_out_valid,
    input  wire logic                 i_out_stall,
    output      logic [COORD_W-1:0]   o_out_col,
    output      logic [COORD_W-1:0]   o_out_row,
    output      logic [PIX_W-1:0]     o_pixel_out,
    output      logic                 o_last_of_run,
    output      logic                 o_frame_done
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int WEXT  = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
    localparam int HEXT  = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [WEXT-1:0]  w_ext;
    logic [HEXT-1:0]  h_ext;
    logic [WEXT-1:0]  w_clamp;
    logic [HEXT-1:0]  h_clamp;
    logic [COL_W-1:0] w_last;
    logic [ROW_W-1:0] h_last;

    logic             in_accept;
    t_pos_flags       pos_flags;
    t_rgb             prev_a;
    t_rgb             prev_b;
    t_result          win_res;
    logic             win_res_valid;
    logic             win_full;
    logic             win_advance;
    logic [COL_W-1:0] win_col;
    t_rgb             win_rgb;
    logic             out_ready;

    logic             done_beat;
    logic             at_origin;
    logic             in_frame;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= RESET_FRAME_WIDTH;
            r_cfg_height <= RESET_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_cfg_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Geometry in use: clamped to the supported range, as last indexes.
    always_comb begin
        w_ext = WEXT'(r_cfg_width);
        h_ext = HEXT'(r_cfg_height);
        if (w_ext < WEXT'(MIN_DIM)) begin
            w_clamp = WEXT'(MIN_DIM);
        end else if (w_ext > WEXT'(MAX_WIDTH)) begin
            w_clamp = WEXT'(MAX_WIDTH);
        end else begin
            w_clamp = w_ext;
        end
        if (h_ext < HEXT'(MIN_DIM)) begin
            h_clamp = HEXT'(MIN_DIM);
        end else if (h_ext > HEXT'(MAX_HEIGHT)) begin
            h_clamp = HEXT'(MAX_HEIGHT);
        end else begin
            h_clamp = h_ext;
        end
        w_last = COL_W'(w_clamp - WEXT'(1));
        h_last = ROW_W'(h_clamp - HEXT'(1));
    end

    // Input handshake: the working register takes a beat when empty or leaving.
    assign o_in_stall = win_full && !win_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    // Position of the next input pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (r_col == w_last) begin
                r_col <= '0;
                r_row <= (r_row == h_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Border flags of the incoming pixel.
    always_comb begin
        pos_flags.x_ge1  = (r_col != '0);
        pos_flags.x_ge2  = (r_col[COL_W-1:1] != '0);
        pos_flags.y_ge1  = (r_row != '0);
        pos_flags.y_ge2  = (r_row[ROW_W-1:1] != '0);
        pos_flags.x_last = (r_col == w_last);
        pos_flags.y_last = (r_row == h_last);
    end

    bb3_line_store #(
        .DEPTH (MAX_WIDTH),
        .AW    (COL_W)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_col),
        .o_rd_a    (prev_a),
        .o_rd_b    (prev_b),
        .i_wr_en   (win_advance),
        .i_wr_addr (win_col),
        .i_wr_a    (win_rgb),
        .i_wr_b    (prev_a)
    );

    bb3_window #(
        .COL_W (COL_W),
        .ROW_W (ROW_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (i_cfg_we),
        .i_load      (in_accept),
        .i_rgb       (i_pixel_in[PIX_W-1:PIX_W-RGB_W]),
        .i_col       (r_col),
        .i_row       (r_row),
        .i_flags     (pos_flags),
        .i_prev_a    (prev_a),
        .i_prev_b    (prev_b),
        .i_res_ready (out_ready),
        .o_res_valid (win_res_valid),
        .o_res       (win_res),
        .o_full      (win_full),
        .o_advance   (win_advance),
        .o_col       (win_col),
        .o_rgb       (win_rgb)
    );

    bb3_out_stage u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (win_res_valid),
        .i_res         (win_res),
        .o_ready       (out_ready),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_col     (o_out_col),
        .o_out_row     (o_out_row),
        .o_pixel_out   (o_pixel_out),
        .o_last_of_run (o_last_of_run),
        .o_frame_done  (o_frame_done)
    );

    // Terms watched by the checks below.
    assign done_beat = o_out_valid && o_frame_done;
    assign at_origin = (r_col == '0) && (r_row == '0);
    assign in_frame  = (r_col <= w_last) && (r_row <= h_last);

    // The frame's final result is always the last one of its input beat.
    `ASSERT_IMPL(a_done_is_last, i_clk, i_rst_n, done_beat, o_last_of_run, "done without last")
    // A register write restarts the frame at the top-left pixel.
    `ASSERT_NEXT(a_cfg_restart, i_clk, i_rst_n, i_cfg_we, at_origin, "no restart after write")
    // The position counters stay inside the frame in use.
    `ASSERT_ALWAYS(a_pos_range, i_clk, i_rst_n, in_frame, "position outside frame")

endmodule

`default_nettype wire
